// ===== sv/bcd_pkg.sv =====
// Shared types and constants of the band classifier with debounce.
// Depends on nothing; every other file but bcd_fifo refers to it by scoped names.
package bcd_pkg;

  localparam int unsigned SAMPLE_W = 21;
  localparam int unsigned THRESH_W = 16;
  localparam int unsigned HITS_W   = 8;
  localparam int unsigned CLASS_W  = 3;
  localparam int unsigned INDEX_W  = 3;

  localparam logic [HITS_W-1:0] HIT_MAX = 8'd255;

  typedef enum logic [CLASS_W-1:0] {
    CLS_GAP   = 3'd0,
    CLS_BAND1 = 3'd1,
    CLS_BAND2 = 3'd2,
    CLS_BAND3 = 3'd3,
    CLS_BAND4 = 3'd4,
    CLS_FAULT = 3'd5
  } class_t;

  // Configuration register indexes.
  localparam logic [INDEX_W-1:0] REG_BAND4_UPPER   = 3'd0;
  localparam logic [INDEX_W-1:0] REG_BAND3_LOWER   = 3'd1;
  localparam logic [INDEX_W-1:0] REG_BAND3_UPPER   = 3'd2;
  localparam logic [INDEX_W-1:0] REG_BAND2_LOWER   = 3'd3;
  localparam logic [INDEX_W-1:0] REG_BAND2_UPPER   = 3'd4;
  localparam logic [INDEX_W-1:0] REG_BAND1_LOWER   = 3'd5;
  localparam logic [INDEX_W-1:0] REG_HITS_FOR_BAND = 3'd6;
  localparam logic [INDEX_W-1:0] REG_HITS_FOR_GAP  = 3'd7;

  // Reset values of the configuration registers.
  localparam logic [THRESH_W-1:0] RST_BAND4_UPPER   = 16'd52;
  localparam logic [THRESH_W-1:0] RST_BAND3_LOWER   = 16'd60;
  localparam logic [THRESH_W-1:0] RST_BAND3_UPPER   = 16'd76;
  localparam logic [THRESH_W-1:0] RST_BAND2_LOWER   = 16'd96;
  localparam logic [THRESH_W-1:0] RST_BAND2_UPPER   = 16'd140;
  localparam logic [THRESH_W-1:0] RST_BAND1_LOWER   = 16'd172;
  localparam logic [HITS_W-1:0]   RST_HITS_FOR_BAND = 8'd4;
  localparam logic [HITS_W-1:0]   RST_HITS_FOR_GAP  = 8'd8;

  typedef struct packed {
    logic [THRESH_W-1:0] band4_upper;
    logic [THRESH_W-1:0] band3_lower;
    logic [THRESH_W-1:0] band3_upper;
    logic [THRESH_W-1:0] band2_lower;
    logic [THRESH_W-1:0] band2_upper;
    logic [THRESH_W-1:0] band1_lower;
    logic [HITS_W-1:0]   hits_for_band;
    logic [HITS_W-1:0]   hits_for_gap;
  } cfg_t;

  typedef struct packed {
    class_t committed_class;
    class_t instant_class;
  } result_t;

endpackage

// ===== sv/bcd_fifo.sv =====
// Small first-in first-out queue of registers, used between the stages.
// Depends on nothing; width and depth come from its parameters (depth of two or more).
module bcd_fifo #(
  parameter int unsigned WIDTH = 3,
  parameter int unsigned DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] wdata,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] rdata,
  output logic             empty
);

  localparam int unsigned PTR_W = $clog2(DEPTH);
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic             do_push;
  logic             do_pop;

  assign full    = (count_r == CNT_W'(DEPTH));
  assign empty   = (count_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= wdata;
    end
  end

endmodule

// ===== sv/bcd_front.sv =====
// Front end: median of three samples and classification against the thresholds.
// Depends on bcd_pkg for the class codes and the configuration struct.
module bcd_front (
  input  bcd_pkg::cfg_t                 cfg,
  input  logic [bcd_pkg::SAMPLE_W-1:0]  sample_first,
  input  logic [bcd_pkg::SAMPLE_W-1:0]  sample_second,
  input  logic [bcd_pkg::SAMPLE_W-1:0]  sample_third,
  output bcd_pkg::class_t               instant_class
);

  logic [bcd_pkg::SAMPLE_W-1:0] a, b, c, med;
  logic [bcd_pkg::SAMPLE_W-1:0] b4u, b3l, b3u, b2l, b2u, b1l;
  logic                         timeout;

  assign a = sample_first;
  assign b = sample_second;
  assign c = sample_third;

  assign b4u = bcd_pkg::SAMPLE_W'(cfg.band4_upper);
  assign b3l = bcd_pkg::SAMPLE_W'(cfg.band3_lower);
  assign b3u = bcd_pkg::SAMPLE_W'(cfg.band3_upper);
  assign b2l = bcd_pkg::SAMPLE_W'(cfg.band2_lower);
  assign b2u = bcd_pkg::SAMPLE_W'(cfg.band2_upper);
  assign b1l = bcd_pkg::SAMPLE_W'(cfg.band1_lower);

  assign timeout = (a == '0) || (b == '0) || (c == '0);

  always_comb begin
    if ((a <= b && b <= c) || (c <= b && b <= a)) begin
      med = b;
    end else if ((b <= a && a <= c) || (c <= a && a <= b)) begin
      med = a;
    end else begin
      med = c;
    end
  end

  // Timeout (a zero sample) wins; then gap ranges are tested before the bands, and bands from 4 down to 1.
  always_comb begin
    if (timeout) begin
      instant_class = bcd_pkg::CLS_FAULT;
    end else if (med > b4u && med < b3l) begin
      instant_class = bcd_pkg::CLS_GAP;
    end else if (med > b3u && med < b2l) begin
      instant_class = bcd_pkg::CLS_GAP;
    end else if (med > b2u && med < b1l) begin
      instant_class = bcd_pkg::CLS_GAP;
    end else if (med <= b4u) begin
      instant_class = bcd_pkg::CLS_BAND4;
    end else if (med >= b3l && med <= b3u) begin
      instant_class = bcd_pkg::CLS_BAND3;
    end else if (med >= b2l && med <= b2u) begin
      instant_class = bcd_pkg::CLS_BAND2;
    end else if (med >= b1l) begin
      instant_class = bcd_pkg::CLS_BAND1;
    end else begin
      instant_class = bcd_pkg::CLS_GAP;
    end
  end

endmodule

// ===== sv/bcd_back.sv =====
// Back end: debounce that commits a class after enough consecutive hits, and a fault at once.
// Depends on bcd_pkg for the class codes, configuration and result structs.
module bcd_back (
  input  logic               clk,
  input  logic               rst_n,
  input  bcd_pkg::cfg_t      cfg,
  input  logic               step,
  input  bcd_pkg::class_t    instant_class,
  output bcd_pkg::result_t   result
);

  bcd_pkg::class_t              committed_r, committed_nxt;
  bcd_pkg::class_t              pending_r, pending_nxt;
  logic [bcd_pkg::HITS_W-1:0]   hit_count_r, hit_count_nxt;
  logic [bcd_pkg::HITS_W-1:0]   need;

  always_comb begin
    committed_nxt = committed_r;
    pending_nxt   = pending_r;
    hit_count_nxt = hit_count_r;
    need = (instant_class == bcd_pkg::CLS_GAP) ? cfg.hits_for_gap : cfg.hits_for_band;
    if (instant_class == bcd_pkg::CLS_FAULT) begin
      committed_nxt = bcd_pkg::CLS_FAULT;
      pending_nxt   = bcd_pkg::CLS_FAULT;
      hit_count_nxt = '0;
    end else begin
      if (instant_class == pending_r) begin
        if (hit_count_r != bcd_pkg::HIT_MAX) begin
          hit_count_nxt = hit_count_r + 1'b1;
        end
      end else begin
        pending_nxt   = instant_class;
        hit_count_nxt = bcd_pkg::HITS_W'(1);
      end
      if (instant_class != committed_r && hit_count_nxt >= need) begin
        committed_nxt = instant_class;
      end
    end
  end

  assign result.committed_class = committed_nxt;
  assign result.instant_class   = instant_class;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      committed_r <= bcd_pkg::CLS_GAP;
      pending_r   <= bcd_pkg::CLS_GAP;
      hit_count_r <= '0;
    end else if (step) begin
      committed_r <= committed_nxt;
      pending_r   <= pending_nxt;
      hit_count_r <= hit_count_nxt;
    end
  end

`ifndef SYNTHESIS
  a_fault_commits: assert property (@(posedge clk) disable iff (!rst_n)
    step && instant_class == bcd_pkg::CLS_FAULT |=> committed_r == bcd_pkg::CLS_FAULT)
    else $error("fault item did not commit the fault class");

  a_commit_from_pending: assert property (@(posedge clk) disable iff (!rst_n)
    step |=> (committed_r == $past(committed_r)) || (committed_r == pending_r))
    else $error("committed class changed to something other than the pending class");

  a_fault_clears_count: assert property (@(posedge clk)
    pending_r == bcd_pkg::CLS_FAULT |-> hit_count_r == '0)
    else $error("hit count not zero while fault is pending");

  a_count_saturates: assert property (@(posedge clk) disable iff (!rst_n)
    step && hit_count_r == bcd_pkg::HIT_MAX && instant_class == pending_r
    |=> hit_count_r == bcd_pkg::HIT_MAX)
    else $error("hit count wrapped past its maximum");
`endif

endmodule

// ===== sv/band_classifier_with_debounce.sv =====
// Top level of the band classifier with debounce: configuration registers,
// front end, class queue, back end and result queue. Depends on bcd_pkg and all bcd_ modules.

// The block takes one word of three charge-time samples per clock cycle while in_full is low
// and returns one result word per input word, in order: the committed class after that word
// and the word's own instant class (0 gap, 1 to 4 band, 5 fault). A word is classified in
// the cycle it is accepted and its class is written to a short class queue; the debounce unit
// takes the class from that queue once the result queue has room and writes the result to
// the result queue, whose head drives the out_ ports. Both queues hold MID_DEPTH and OUT_DEPTH
// words; with out_pop held high the sustained rate is one word per cycle, and
// when the result side stalls the queues fill and in_full rises after at most MID_DEPTH plus
// OUT_DEPTH words. Configuration writes are always taken (cfg_ready is high) and should be
// issued only while no word is in flight.
module band_classifier_with_debounce #(
  parameter int unsigned MID_DEPTH = 2,
  parameter int unsigned OUT_DEPTH = 2
) (
  input  logic                          clk,
  input  logic                          rst_n,
  // Input word channel.
  input  logic                          in_push,
  output logic                          in_full,
  input  logic [bcd_pkg::SAMPLE_W-1:0]  in_sample_first,
  input  logic [bcd_pkg::SAMPLE_W-1:0]  in_sample_second,
  input  logic [bcd_pkg::SAMPLE_W-1:0]  in_sample_third,
  // Result word channel.
  output logic                          out_empty,
  input  logic                          out_pop,
  output logic [bcd_pkg::CLASS_W-1:0]   out_committed_class,
  output logic [bcd_pkg::CLASS_W-1:0]   out_instant_class,
  // Configuration write channel.
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [bcd_pkg::INDEX_W-1:0]   cfg_index,
  input  logic [bcd_pkg::THRESH_W-1:0]  cfg_data
);

  localparam int unsigned CLS_BITS = $bits(bcd_pkg::class_t);
  localparam int unsigned RES_BITS = $bits(bcd_pkg::result_t);

  bcd_pkg::cfg_t     cfg_r;
  bcd_pkg::class_t   front_class;
  bcd_pkg::class_t   back_class;
  bcd_pkg::result_t  back_result;
  bcd_pkg::result_t  out_word;
  logic [CLS_BITS-1:0] mid_rdata;
  logic [RES_BITS-1:0] out_rdata;
  logic              mid_empty;
  logic              res_full;
  logic              back_step;

  // Configuration registers; a write goes straight into its register, so the channel is always ready.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.band4_upper   <= bcd_pkg::RST_BAND4_UPPER;
      cfg_r.band3_lower   <= bcd_pkg::RST_BAND3_LOWER;
      cfg_r.band3_upper   <= bcd_pkg::RST_BAND3_UPPER;
      cfg_r.band2_lower   <= bcd_pkg::RST_BAND2_LOWER;
      cfg_r.band2_upper   <= bcd_pkg::RST_BAND2_UPPER;
      cfg_r.band1_lower   <= bcd_pkg::RST_BAND1_LOWER;
      cfg_r.hits_for_band <= bcd_pkg::RST_HITS_FOR_BAND;
      cfg_r.hits_for_gap  <= bcd_pkg::RST_HITS_FOR_GAP;
    end else if (cfg_valid) begin
      case (cfg_index)
        bcd_pkg::REG_BAND4_UPPER:   cfg_r.band4_upper <= cfg_data;
        bcd_pkg::REG_BAND3_LOWER:   cfg_r.band3_lower <= cfg_data;
        bcd_pkg::REG_BAND3_UPPER:   cfg_r.band3_upper <= cfg_data;
        bcd_pkg::REG_BAND2_LOWER:   cfg_r.band2_lower <= cfg_data;
        bcd_pkg::REG_BAND2_UPPER:   cfg_r.band2_upper <= cfg_data;
        bcd_pkg::REG_BAND1_LOWER:   cfg_r.band1_lower <= cfg_data;
        bcd_pkg::REG_HITS_FOR_BAND: cfg_r.hits_for_band <= cfg_data[bcd_pkg::HITS_W-1:0];
        bcd_pkg::REG_HITS_FOR_GAP:  cfg_r.hits_for_gap <= cfg_data[bcd_pkg::HITS_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // Front end classifies the incoming word straight into the class queue.
  bcd_front u_front (
    .cfg           (cfg_r),
    .sample_first  (in_sample_first),
    .sample_second (in_sample_second),
    .sample_third  (in_sample_third),
    .instant_class (front_class)
  );

  bcd_fifo #(
    .WIDTH (CLS_BITS),
    .DEPTH (MID_DEPTH)
  ) u_mid_fifo (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (in_push),
    .wdata (front_class),
    .full  (in_full),
    .pop   (back_step),
    .rdata (mid_rdata),
    .empty (mid_empty)
  );

  // The debounce unit advances whenever a class waits and the result queue has room.
  assign back_step  = !mid_empty && !res_full;
  assign back_class = bcd_pkg::class_t'(mid_rdata);

  bcd_back u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg           (cfg_r),
    .step          (back_step),
    .instant_class (back_class),
    .result        (back_result)
  );

  bcd_fifo #(
    .WIDTH (RES_BITS),
    .DEPTH (OUT_DEPTH)
  ) u_out_fifo (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (back_step),
    .wdata (back_result),
    .full  (res_full),
    .pop   (out_pop),
    .rdata (out_rdata),
    .empty (out_empty)
  );

  assign out_word            = bcd_pkg::result_t'(out_rdata);
  assign out_committed_class = out_word.committed_class;
  assign out_instant_class   = out_word.instant_class;

endmodule
